// ----- rtl/lrl_pkg.sv -----
// ----------------------------------------------------------------------------
// lrl_pkg
// Shared types for the recency list: request and result beats, the stored
// entry, the operation codes, controller states and controller commands.
// ----------------------------------------------------------------------------
package lrl_pkg;

  // Operation codes carried in the op field of a request.
  localparam logic OP_TOUCH  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Width of the fill level field in a result.
  localparam int unsigned FILL_W = 4;

  // Request beat.
  typedef struct packed {
    logic        op;
    logic [31:0] command_tag;
    logic [15:0] server_port;
    logic [15:0] client_port;
    logic [31:0] dir_tag;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [15:0]       found_server_port;
    logic [15:0]       found_client_port;
    logic [31:0]       found_dir_tag;
    logic [FILL_W-1:0] fill_level;
  } rsp_t;

  // One stored list entry.
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] server_port;
    logic [15:0] client_port;
    logic [31:0] dir_tag;
  } entry_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and its match vectors
    logic commit;  // update the list and load the result register
  } cmd_t;

endpackage

// ----- rtl/lrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrl_ctrl
// Controller: takes one request beat at a time, orders the datapath to
// capture it, then to commit the list update once the result register is
// free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lrl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lrl_pkg::cmd_t cmd
);

  lrl_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid || out_ready;

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      lrl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lrl_pkg::ST_UPDATE;
        end
      end
      lrl_pkg::ST_UPDATE: begin
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = lrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lrl_datapath.sv -----
// ----------------------------------------------------------------------------
// lrl_datapath
// Datapath: a row of entry cells ordered oldest to newest, per-cell
// comparators whose match vectors are registered with the request, and the
// shift/append and lookup select logic that runs on commit.
// ----------------------------------------------------------------------------
module lrl_datapath #(
  parameter int unsigned CAPACITY = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  lrl_pkg::cmd_t cmd,
  input  lrl_pkg::req_t in_data,
  output lrl_pkg::rsp_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  lrl_pkg::entry_t cells      [CAPACITY];
  lrl_pkg::entry_t cells_next [CAPACITY];
  logic [CW-1:0]   count, count_next;
  lrl_pkg::req_t   req;
  logic [CAPACITY-1:0] full_match, key_match;
  logic [CAPACITY-1:0] full_match_next, key_match_next;
  logic [CAPACITY-1:0] valid_vec;

  logic                found, full, remove;
  logic [CAPACITY-1:0] found_low, remove_vec, shift_mask, key_low;
  logic [CW-1:0]       base;
  lrl_pkg::entry_t     new_entry, pick;
  lrl_pkg::rsp_t       rsp_next;
  logic [CW+lrl_pkg::FILL_W-1:0] fill_ext;

  // Cells below the count hold live entries.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = (CW'(i) < count);
    end
  end

  // Per-cell comparison against the incoming request.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      key_match_next[i]  = valid_vec[i] && (cells[i].key == in_data.command_tag);
      full_match_next[i] = key_match_next[i]
                           && (cells[i].server_port == in_data.server_port)
                           && (cells[i].client_port == in_data.client_port)
                           && (cells[i].dir_tag == in_data.dir_tag);
    end
  end

  // Request and match vectors are captured when the beat is taken.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req        <= in_data;
      key_match  <= key_match_next;
      full_match <= full_match_next;
    end
  end

  // Touch: pick the cell to drop (the match, or the oldest when full), and
  // mark every cell at or above it for a shift down by one.
  always_comb begin
    found      = |full_match;
    full       = (count == CW'(CAPACITY));
    remove     = found || full;
    found_low  = full_match & (~full_match + CAPACITY'(1));
    remove_vec = found ? found_low : CAPACITY'(1);
    shift_mask = remove ? ~(remove_vec - CAPACITY'(1)) : '0;
    base       = remove ? (count - CW'(1)) : count;
    new_entry.key         = req.command_tag;
    new_entry.server_port = req.server_port;
    new_entry.client_port = req.client_port;
    new_entry.dir_tag     = req.dir_tag;
  end

  // Next value of each cell: append slot, shifted slot or unchanged.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g < CAPACITY - 1) begin : g_shift
      always_comb begin
        if (CW'(g) == base) begin
          cells_next[g] = new_entry;
        end else if (shift_mask[g] && (CW'(g) < base)) begin
          cells_next[g] = cells[g+1];
        end else begin
          cells_next[g] = cells[g];
        end
      end
    end else begin : g_top
      always_comb begin
        if (CW'(g) == base) begin
          cells_next[g] = new_entry;
        end else begin
          cells_next[g] = cells[g];
        end
      end
    end

    // Cells only change on a touch commit.
    always_ff @(posedge clk) begin
      if (cmd.commit && (req.op == lrl_pkg::OP_TOUCH)) begin
        cells[g] <= cells_next[g];
      end
    end
  end

  // Lookup: the oldest cell whose key matches drives the found fields.
  always_comb begin
    key_low = key_match & (~key_match + CAPACITY'(1));
    pick    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pick = pick | (cells[i] & {$bits(lrl_pkg::entry_t){key_low[i]}});
    end
  end

  // Result and count for the committed request.
  always_comb begin
    rsp_next = '0;
    if (req.op == lrl_pkg::OP_TOUCH) begin
      count_next       = base + CW'(1);
      rsp_next.hit     = found;
      rsp_next.evicted = !found && full;
    end else begin
      count_next                 = count;
      rsp_next.hit               = |key_match;
      rsp_next.found_server_port = pick.server_port;
      rsp_next.found_client_port = pick.client_port;
      rsp_next.found_dir_tag     = pick.dir_tag;
    end
    fill_ext            = {{lrl_pkg::FILL_W{1'b0}}, count_next};
    rsp_next.fill_level = fill_ext[lrl_pkg::FILL_W-1:0];
  end

  // Entry count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= rsp_next;
    end
  end

endmodule

// ----- rtl/lru_recency_list.sv -----
// ----------------------------------------------------------------------------
// lru_recency_list
// Recency list of up to CAPACITY entries with touch and lookup requests.
// ----------------------------------------------------------------------------
// Each request beat is handled in turn: in the cycle it is accepted every cell
// is compared against it in parallel and the match vectors are registered;
// then the list is shifted and appended (touch) or the oldest
// key match is selected (lookup), and the result is loaded into the output
// register. A new request is accepted while a result still waits there; the
// update state holds until that register is free. A touch moves an equal
// entry to the newest place, or appends the entry, evicting the oldest one
// when the list is full. A lookup returns the oldest entry with the given
// command tag and leaves the order unchanged. fill_level is the entry count
// after the request, taken modulo 16.
module lru_recency_list #(
  parameter int unsigned CAPACITY = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lrl_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lrl_pkg::rsp_t out_data
);

  lrl_pkg::cmd_t cmd;

  // Sequencing of request beats and the result handshake.
  lrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Entry cells, comparators and result register.
  lrl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
